// File: hdl/spq_pkg.sv
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int OCC_W   = 5;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [PRIO_W-1:0]   item_priority;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  head_value;
    logic [1:0]                 status;
    logic [OCC_W-1:0]           occupancy;
  } out_word_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_INSERT_IN,
    DP_INSERT_HELD,
    DP_REMOVE_HEAD,
    DP_REMOVE_MATCH
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t     op;
    logic       hold_item;
    logic       out_load;
    logic       out_head;
    status_t    out_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic found;
  } dp_stat_t;

  typedef enum logic {
    S_IDLE,
    S_REINSERT
  } state_t;

endpackage

// File: hdl/spq_datapath.sv
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_word_t out_word
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] val_r [CAPACITY];
  logic signed [PRIO_W-1:0]  pri_r [CAPACITY];
  logic signed [VALUE_W-1:0] val_nxt [CAPACITY];
  logic signed [PRIO_W-1:0]  pri_nxt [CAPACITY];
  logic [CW-1:0]             count_r, count_nxt;

  logic signed [VALUE_W-1:0] held_val_r;
  logic signed [PRIO_W-1:0]  held_pri_r;
  out_word_t                 out_word_r;

  logic signed [VALUE_W-1:0] ins_val;
  logic signed [PRIO_W-1:0]  ins_pri;
  logic [CAPACITY-1:0]       live, ahead, ahead_prev, match, before_first, take_next;

  assign ins_val = (cmd.op == DP_INSERT_HELD) ? held_val_r : in_word.item_value;
  assign ins_pri = (cmd.op == DP_INSERT_HELD) ? held_pri_r : in_word.item_priority;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]  = CW'(i) < count_r;
      ahead[i] = live[i] && (pri_r[i] >= ins_pri);
      match[i] = live[i] && (val_r[i] == in_word.item_value);
    end
  end

  assign ahead_prev = {ahead[CAPACITY-2:0], 1'b1};
  // ones strictly below the first matching entry
  assign before_first = (match - CAPACITY'(1)) & ~match;
  assign take_next = (cmd.op == DP_REMOVE_MATCH) ? ~before_first : '1;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(CAPACITY));
  assign stat.found = |match;

  always_comb begin
    int prv;
    int nxt;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      prv = (i == 0) ? 0 : i - 1;
      nxt = (i == CAPACITY - 1) ? i : i + 1;
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
      case (cmd.op)
        DP_INSERT_IN, DP_INSERT_HELD: begin
          if (!ahead[i]) begin
            if (ahead_prev[i]) begin
              val_nxt[i] = ins_val;
              pri_nxt[i] = ins_pri;
            end else begin
              val_nxt[i] = val_r[prv];
              pri_nxt[i] = pri_r[prv];
            end
          end
        end
        DP_REMOVE_HEAD, DP_REMOVE_MATCH: begin
          if (take_next[i]) begin
            val_nxt[i] = val_r[nxt];
            pri_nxt[i] = pri_r[nxt];
          end
        end
        default: begin
        end
      endcase
    end
    case (cmd.op)
      DP_INSERT_IN, DP_INSERT_HELD:    count_nxt = count_r + CW'(1);
      DP_REMOVE_HEAD, DP_REMOVE_MATCH: count_nxt = count_r - CW'(1);
      default:                         count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    if (cmd.hold_item) begin
      held_val_r <= in_word.item_value;
      held_pri_r <= in_word.item_priority;
    end
    if (cmd.out_load) begin
      out_word_r.head_value <= cmd.out_head ? val_r[0] : '0;
      out_word_r.status     <= cmd.out_status;
      out_word_r.occupancy  <= OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_word = out_word_r;

endmodule

// File: hdl/spq_ctrl.sv
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_CHANGE) && stat.found) begin
          state_nxt = S_REINSERT;
        end
      end
      S_REINSERT: state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: DP_NOP, hold_item: 1'b0, out_load: 1'b0, out_head: 1'b0,
            out_status: ST_OK};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUSH: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.op = DP_INSERT_IN;
              end
            end
            CMD_POP: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.op       = DP_REMOVE_HEAD;
                cmd.out_head = 1'b1;
              end
            end
            CMD_PEEK: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.out_head = 1'b1;
              end
            end
            CMD_CHANGE: begin
              if (stat.found) begin
                cmd.op        = DP_REMOVE_MATCH;
                cmd.hold_item = 1'b1;
              end else begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REINSERT: begin
        cmd.op       = DP_INSERT_HELD;
        cmd.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // the output slot is always free while the moved entry goes back in
  a_reinsert_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINSERT |-> !out_valid_r)
    else $error("output word pending during reinsert");

  a_reinsert_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINSERT |=> out_valid_r && state_r == S_IDLE)
    else $error("change command produced no word");

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_INSERT_IN |-> !stat.full)
    else $error("insert issued into a full store");

  a_remove_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_REMOVE_HEAD || cmd.op == DP_REMOVE_MATCH) |-> !stat.empty)
    else $error("remove issued on an empty store");

endmodule

// File: hdl/sorted_priority_queue_core.sv
// sorted priority queue, up to CAPACITY entries kept in descending priority
// order; equal priorities keep arrival order
// input channel in_valid/in_ready/in_word carries one command word:
//   push, pop, peek or change-priority of the first entry holding a value
// output channel out_valid/out_ready/out_word returns one word per command:
//   head value (pop/peek), status and occupancy after the command
// result: the word is registered and shows in the cycle after accept, but a
//   change-priority that finds its value first removes it and then inserts
//   it in the reinsert state, as the register array shifts once per cycle
// throughput: one command per cycle for push, pop, peek and failed change
//   while the receiver takes each word; no command is taken while reinserting
// a new command is taken in the same cycle the pending result is taken, so
//   a stalled receiver holds off the input only while a word waits
// reset: synchronous, active low; the queue comes up empty and no word is
//   pending; stored entries are not cleared, only the count
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_word.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

// File: test/tb_top.sv
module tb_top
  import spq_pkg::*;
();
  localparam int QDEPTH      = 16;
  localparam int RAND_ITEMS  = 1526;
  localparam int STALL_LIMIT = 3000;

  class sorted_queue_shadow;
    logic signed [VALUE_W-1:0] vals [QDEPTH];
    logic signed [PRIO_W-1:0]  pris [QDEPTH];
    int unsigned               count;
    out_word_t                 due_words [$];
    int                        errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    task report_mismatch(string msg);
      $display("tb_top: mismatch: %s", msg);
      errors++;
    endtask

    // goes behind every entry of greater or equal priority
    function void insert_sorted(logic signed [VALUE_W-1:0] v,
                                logic signed [PRIO_W-1:0] p);
      int pos;
      pos = 0;
      while (pos < count && pris[pos] >= p) pos++;
      for (int i = count; i > pos; i--) begin
        vals[i] = vals[i-1];
        pris[i] = pris[i-1];
      end
      vals[pos] = v;
      pris[pos] = p;
      count++;
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i + 1 < count; i++) begin
        vals[i] = vals[i+1];
        pris[i] = pris[i+1];
      end
      count--;
    endfunction

    function void note_command(in_word_t w);
      out_word_t r;
      cmd_t      op;
      int        pos;
      bit        hit;
      r  = '0;
      op = cmd_t'(w.cmd);
      r.status = ST_OK;
      case (op)
        CMD_PUSH: begin
          if (count >= QDEPTH) r.status = ST_FULL;
          else insert_sorted(w.item_value, w.item_priority);
        end
        CMD_POP: begin
          if (count == 0) r.status = ST_EMPTY;
          else begin
            r.head_value = vals[0];
            remove_at(0);
          end
        end
        CMD_PEEK: begin
          if (count == 0) r.status = ST_EMPTY;
          else r.head_value = vals[0];
        end
        default: begin
          hit = 0;
          pos = 0;
          for (int i = 0; i < count && !hit; i++) begin
            if (vals[i] == w.item_value) begin
              hit = 1;
              pos = i;
            end
          end
          if (!hit) r.status = ST_NOT_FOUND;
          else begin
            remove_at(pos);
            insert_sorted(w.item_value, w.item_priority);
          end
        end
      endcase
      r.occupancy = count[OCC_W-1:0];
      due_words.push_back(r);
    endfunction

    task check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word head %0d status %0d occ %0d",
                                  got.head_value, got.status, got.occupancy));
      end else begin
        want = due_words.pop_front();
        if (got.head_value !== want.head_value)
          report_mismatch($sformatf("head_value %0d, want %0d", got.head_value,
                                    want.head_value));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status,
                                    want.status));
        if (got.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy,
                                    want.occupancy));
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  bit calm = 0;
  int quiet_cycles = 0;

  sorted_queue_shadow shadow = new();

  sorted_priority_queue_core #(.CAPACITY(QDEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 27);
  endfunction

  function automatic in_word_t make_cmd(cmd_t op, logic signed [VALUE_W-1:0] v,
                                        logic signed [PRIO_W-1:0] p);
    in_word_t w;
    w.cmd           = op;
    w.item_value    = v;
    w.item_priority = p;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task send_word(in_word_t w);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    shadow.note_command(w);
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= !take_break();

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      shadow.check_word(out_word);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  logic signed [VALUE_W-1:0] hot_vals [8] = '{32'sd0, 32'sd1, -32'sd1, 32'sd7,
                                               32'h7FFF_FFFF, 32'h8000_0000,
                                               32'sd42, 32'h55AA_55AA};

  function automatic in_word_t random_word(int mode);
    int                        roll;
    cmd_t                      op;
    logic signed [VALUE_W-1:0] v;
    logic signed [PRIO_W-1:0]  p;
    roll = $urandom_range(0, 99);
    case (mode)
      1:       op = roll < 65 ? CMD_PUSH : roll < 75 ? CMD_POP : roll < 80 ? CMD_PEEK : CMD_CHANGE;
      2:       op = roll < 15 ? CMD_PUSH : roll < 70 ? CMD_POP : roll < 80 ? CMD_PEEK : CMD_CHANGE;
      default: op = roll < 35 ? CMD_PUSH : roll < 60 ? CMD_POP : roll < 70 ? CMD_PEEK : CMD_CHANGE;
    endcase
    // a small pool of values so change finds targets and duplicates occur
    if ($urandom_range(0, 99) < 60) v = hot_vals[$urandom_range(0, 7)];
    else v = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 50) p = PRIO_W'($urandom_range(0, 6)) - 16'sd3;
    else if (roll < 85) p = PRIO_W'($urandom);
    else p = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return make_cmd(op, v, p);
  endfunction

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue cases
    send_word(make_cmd(CMD_POP, 32'sd5, 16'sd0));
    send_word(make_cmd(CMD_PEEK, 32'sd5, 16'sd0));
    send_word(make_cmd(CMD_CHANGE, 32'sd5, 16'sd1));
    // fill up, extremes and ties, duplicate value zero
    send_word(make_cmd(CMD_PUSH, 32'h7FFF_FFFF, 16'sd0));
    send_word(make_cmd(CMD_PUSH, 32'h8000_0000, 16'sd0));
    send_word(make_cmd(CMD_PUSH, 32'sd0, 16'sh7FFF));
    send_word(make_cmd(CMD_PUSH, -32'sd1, 16'sh8000));
    for (int i = 0; i < 11; i++)
      send_word(make_cmd(CMD_PUSH, 32'sd100 + i, PRIO_W'(i % 3) - 16'sd1));
    send_word(make_cmd(CMD_PUSH, 32'sd0, 16'sh8000));
    // full queue: push dropped, change still fits
    send_word(make_cmd(CMD_PUSH, 32'sd999, 16'sh7FFF));
    send_word(make_cmd(CMD_CHANGE, -32'sd1, 16'sh7FFF));
    send_word(make_cmd(CMD_CHANGE, 32'sd12345, 16'sd0));
    send_word(make_cmd(CMD_PEEK, 32'sd0, 16'sd0));
    send_word(make_cmd(CMD_POP, 32'sd0, 16'sd0));

    mode = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) mode = $urandom_range(0, 2);
      calm = (n >= 700 && n < 1000);
      send_word(random_word(mode));
    end
    calm = 0;
    in_valid <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

// File: filelist.f
hdl/spq_pkg.sv
hdl/spq_datapath.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue_core.sv
test/tb_top.sv
